/* src/grid_region_rotator_core_assert.svh */
// Assertion macros for the grid region rotator RTL.
`ifndef GRID_REGION_ROTATOR_CORE_ASSERT_SVH
`define GRID_REGION_ROTATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge out of reset.
`define GRR_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("grid rotator assertion failed");

// Same-cycle implication.
`define GRR_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid rotator implication failed");

// Next-cycle implication.
`define GRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid rotator next-cycle check failed");

`else

`define GRR_ASSERT(label, prop)
`define GRR_ASSERT_IMPLIES(label, ante, cons)
`define GRR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* src/grr_pkg.sv */
// Package with payload types, codes and control structs of the grid region rotator.
package grr_pkg;

    localparam int VALUE_W = 13;
    localparam int SIDE_W  = 7;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

    localparam logic [1:0] FUNC_FILL   = 2'd0;
    localparam logic [1:0] FUNC_ROTATE = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [5:0] row;
        logic [5:0] col;
        logic [4:0] radius;
        logic       counter_clockwise;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0] cell_value;
        logic               status;
    } rsp_t;

    // Memory commands from the sequencer to the store
    typedef struct packed {
        logic grid_rd;
        logic grid_wr;
        logic buf_rd;
        logic to_buf;
        logic to_grid;
    } mem_ctl_t;

endpackage

/* src/grr_store.sv */
// Grid memory and window buffer with the delayed copy paths between them.
module grr_store #(
    parameter int MAX_SIDE = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  grr_pkg::mem_ctl_t                      ctl,
    input  logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]   grid_addr,
    input  logic [grr_pkg::VALUE_W-1:0]            grid_wdata,
    input  logic [((((MAX_SIDE > 63) ? 63 : ((MAX_SIDE % 2 == 1) ? MAX_SIDE : MAX_SIDE - 1))
                   ** 2 > 1) ? $clog2(((MAX_SIDE > 63) ? 63 : ((MAX_SIDE % 2 == 1) ?
                   MAX_SIDE : MAX_SIDE - 1)) ** 2) : 1)-1:0] buf_addr,
    output logic [grr_pkg::VALUE_W-1:0]            grid_rdata
);

    localparam int GRID_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W     = $clog2(GRID_DEPTH);
    localparam int WIN_MAX    = (MAX_SIDE > 63) ? 63 :
                                ((MAX_SIDE % 2 == 1) ? MAX_SIDE : MAX_SIDE - 1);
    localparam int BUF_DEPTH  = WIN_MAX * WIN_MAX;
    localparam int BUF_AW     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    logic [grr_pkg::VALUE_W-1:0] grid_mem [GRID_DEPTH];
    logic [grr_pkg::VALUE_W-1:0] buf_mem  [BUF_DEPTH];

    logic [grr_pkg::VALUE_W-1:0] grid_rdata_reg;
    logic [grr_pkg::VALUE_W-1:0] buf_rdata_reg;
    logic                        to_buf_vld_reg;
    logic                        to_grid_vld_reg;
    logic [BUF_AW-1:0]           buf_dst_reg;
    logic [ADDR_W-1:0]           grid_dst_reg;

    logic                        grid_we;
    logic [ADDR_W-1:0]           grid_waddr;
    logic [grr_pkg::VALUE_W-1:0] grid_wd;

    // Grid write port: fill data now, or buffer data in the cycle after its read
    always_comb
    begin
        grid_we    = ctl.grid_wr | to_grid_vld_reg;
        grid_waddr = to_grid_vld_reg ? grid_dst_reg : grid_addr;
        grid_wd    = to_grid_vld_reg ? buf_rdata_reg : grid_wdata;
    end

    // Grid memory
    always_ff @(posedge clk)
    begin
        if (grid_we)
        begin
            grid_mem[grid_waddr] <= grid_wd;
        end
        if (ctl.grid_rd)
        begin
            grid_rdata_reg <= grid_mem[grid_addr];
        end
    end

    // Window buffer, written with grid data in the cycle after the grid read
    always_ff @(posedge clk)
    begin
        if (to_buf_vld_reg)
        begin
            buf_mem[buf_dst_reg] <= grid_rdata_reg;
        end
        if (ctl.buf_rd)
        begin
            buf_rdata_reg <= buf_mem[buf_addr];
        end
    end

    // Copy-path flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            to_buf_vld_reg  <= 1'b0;
            to_grid_vld_reg <= 1'b0;
        end
        else
        begin
            to_buf_vld_reg  <= ctl.to_buf;
            to_grid_vld_reg <= ctl.to_grid;
        end
    end

    // Destination addresses are registered and follow the read in the next cycle
    always_ff @(posedge clk)
    begin
        buf_dst_reg  <= buf_addr;
        grid_dst_reg <= grid_addr;
    end

    assign grid_rdata = grid_rdata_reg;

endmodule

/* src/grr_seq.sv */
// Sequencer: address stepping over grid and window, result register.
`include "grid_region_rotator_core_assert.svh"

module grr_seq #(
    parameter int MAX_SIDE = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [grr_pkg::SIDE_W-1:0]             side,
    input  logic                                   req_valid,
    output logic                                   req_ready,
    input  grr_pkg::req_t                          req_data,
    output logic                                   rsp_valid,
    input  logic                                   rsp_ready,
    output grr_pkg::rsp_t                          rsp_data,
    output grr_pkg::mem_ctl_t                      ctl,
    output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]   grid_addr,
    output logic [grr_pkg::VALUE_W-1:0]            grid_wdata,
    output logic [((((MAX_SIDE > 63) ? 63 : ((MAX_SIDE % 2 == 1) ? MAX_SIDE : MAX_SIDE - 1))
                   ** 2 > 1) ? $clog2(((MAX_SIDE > 63) ? 63 : ((MAX_SIDE % 2 == 1) ?
                   MAX_SIDE : MAX_SIDE - 1)) ** 2) : 1)-1:0] buf_addr,
    input  logic [grr_pkg::VALUE_W-1:0]            grid_rdata
);

    localparam int ADDR_W    = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int CALC_W    = ADDR_W + 8;
    localparam int WIN_MAX   = (MAX_SIDE > 63) ? 63 :
                               ((MAX_SIDE % 2 == 1) ? MAX_SIDE : MAX_SIDE - 1);
    localparam int BUF_DEPTH = WIN_MAX * WIN_MAX;
    localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int BCALC_W   = 13;
    localparam int SW        = grr_pkg::SIDE_W;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_FILL     = 8'b0000_0010,
        S_COPY     = 8'b0000_0100,
        S_COPY_END = 8'b0000_1000,
        S_MOVE     = 8'b0001_0000,
        S_MOVE_END = 8'b0010_0000,
        S_CELL     = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t                      state_reg, state_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    grr_pkg::rsp_t               rsp_reg, rsp_next;
    logic [SW-1:0]               i_reg, i_next;
    logic [SW-1:0]               j_reg, j_next;
    logic [SW-1:0]               lim_reg, lim_next;
    logic [ADDR_W-1:0]           gaddr_reg, gaddr_next;
    logic [ADDR_W-1:0]           gstart_reg, gstart_next;
    logic [ADDR_W-1:0]           grow_step_reg, grow_step_next;
    logic [grr_pkg::VALUE_W-1:0] value_reg, value_next;
    logic [BUF_AW-1:0]           baddr_reg, baddr_next;
    logic [BUF_AW-1:0]           bbase_reg, bbase_next;
    logic [BUF_AW-1:0]           brow_step_reg, brow_step_next;
    logic                        ccw_reg, ccw_next;
    logic                        rd_ok_reg, rd_ok_next;
    logic                        status_reg, status_next;

    // Decode of an incoming item
    logic [SW-1:0]     row7, col7, rad7, w7;
    logic              win_ok, cell_ok;
    logic [5:0]        top6, left6;
    logic [ADDR_W-1:0] win_start, cell_start;
    logic [BUF_AW-1:0] cw_base, ccw_base;

    // Sweep stepping
    logic [SW-1:0]     lim_m1;
    logic              row_last, all_last;
    logic [BUF_AW-1:0] bbase_step;
    logic [2:0]        access_vec;

    // Window bounds and start addresses
    always_comb
    begin
        row7    = {1'b0, req_data.row};
        col7    = {1'b0, req_data.col};
        rad7    = {2'b00, req_data.radius};
        w7      = {1'b0, req_data.radius, 1'b1};
        win_ok  = (row7 >= rad7) && (col7 >= rad7) &&
                  ((row7 + rad7) < side) && ((col7 + rad7) < side);
        cell_ok = (row7 < side) && (col7 < side);
        top6    = req_data.row - {1'b0, req_data.radius};
        left6   = req_data.col - {1'b0, req_data.radius};
        win_start  = ADDR_W'(CALC_W'(top6) * CALC_W'(MAX_SIDE) + CALC_W'(left6));
        cell_start = ADDR_W'(CALC_W'(req_data.row) * CALC_W'(MAX_SIDE) +
                             CALC_W'(req_data.col));
        cw_base  = BUF_AW'(BCALC_W'({req_data.radius, 1'b0}) * BCALC_W'(WIN_MAX));
        ccw_base = BUF_AW'(BCALC_W'({req_data.radius, 1'b0}));
    end

    // End-of-row and end-of-sweep detection
    always_comb
    begin
        lim_m1     = lim_reg - SW'(1);
        row_last   = (j_reg == lim_m1);
        all_last   = row_last && (i_reg == lim_m1);
        bbase_step = ccw_reg ? (bbase_reg - BUF_AW'(1)) : (bbase_reg + BUF_AW'(1));
    end

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        lim_next       = lim_reg;
        gaddr_next     = gaddr_reg;
        gstart_next    = gstart_reg;
        grow_step_next = grow_step_reg;
        value_next     = value_reg;
        baddr_next     = baddr_reg;
        bbase_next     = bbase_reg;
        brow_step_next = brow_step_reg;
        ccw_next       = ccw_reg;
        rd_ok_next     = rd_ok_reg;
        status_next    = status_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    i_next      = '0;
                    j_next      = '0;
                    rd_ok_next  = 1'b0;
                    status_next = 1'b0;
                    case (req_data.func)
                        grr_pkg::FUNC_FILL:
                        begin
                            lim_next       = side;
                            gaddr_next     = '0;
                            value_next     = grr_pkg::VALUE_W'(1);
                            grow_step_next = ADDR_W'(MAX_SIDE + 1) - ADDR_W'(side);
                            state_next     = (side == '0) ? S_DONE : S_FILL;
                        end
                        grr_pkg::FUNC_ROTATE:
                        begin
                            lim_next       = w7;
                            gaddr_next     = win_start;
                            gstart_next    = win_start;
                            grow_step_next = ADDR_W'(MAX_SIDE + 1) - ADDR_W'(w7);
                            baddr_next     = '0;
                            brow_step_next = BUF_AW'(WIN_MAX + 1) - BUF_AW'(w7);
                            ccw_next       = req_data.counter_clockwise;
                            bbase_next     = req_data.counter_clockwise ? ccw_base : cw_base;
                            status_next    = !win_ok;
                            state_next     = win_ok ? S_COPY : S_DONE;
                        end
                        grr_pkg::FUNC_READ:
                        begin
                            gaddr_next  = cell_start;
                            rd_ok_next  = cell_ok;
                            status_next = !cell_ok;
                            state_next  = cell_ok ? S_CELL : S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_FILL, S_COPY, S_MOVE:
            begin
                // Shared row-major stepping over the current square
                value_next = value_reg + grr_pkg::VALUE_W'(1);
                if (row_last)
                begin
                    j_next     = '0;
                    i_next     = i_reg + SW'(1);
                    gaddr_next = gaddr_reg + grow_step_reg;
                end
                else
                begin
                    j_next     = j_reg + SW'(1);
                    gaddr_next = gaddr_reg + ADDR_W'(1);
                end

                // Buffer address: straight in copy, transposed walk in move
                if (state_reg == S_COPY)
                begin
                    baddr_next = row_last ? (baddr_reg + brow_step_reg)
                                          : (baddr_reg + BUF_AW'(1));
                end
                else if (state_reg == S_MOVE)
                begin
                    if (row_last)
                    begin
                        bbase_next = bbase_step;
                        baddr_next = bbase_step;
                    end
                    else
                    begin
                        baddr_next = ccw_reg ? (baddr_reg + BUF_AW'(WIN_MAX))
                                             : (baddr_reg - BUF_AW'(WIN_MAX));
                    end
                end

                if (all_last)
                begin
                    case (state_reg)
                        S_FILL:  state_next = S_DONE;
                        S_COPY:  state_next = S_COPY_END;
                        default: state_next = S_MOVE_END;
                    endcase
                end
            end

            S_COPY_END:
            begin
                i_next     = '0;
                j_next     = '0;
                gaddr_next = gstart_reg;
                baddr_next = bbase_reg;
                state_next = S_MOVE;
            end

            S_MOVE_END, S_CELL:
            begin
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.cell_value = rd_ok_reg ? grid_rdata : '0;
                    rsp_next.status     = status_reg;
                    rsp_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rsp_reg       <= rsp_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        lim_reg       <= lim_next;
        gaddr_reg     <= gaddr_next;
        gstart_reg    <= gstart_next;
        grow_step_reg <= grow_step_next;
        value_reg     <= value_next;
        baddr_reg     <= baddr_next;
        bbase_reg     <= bbase_next;
        brow_step_reg <= brow_step_next;
        ccw_reg       <= ccw_next;
        rd_ok_reg     <= rd_ok_next;
        status_reg    <= status_next;
    end

    // Memory commands
    always_comb
    begin
        ctl.grid_wr = (state_reg == S_FILL);
        ctl.grid_rd = (state_reg == S_COPY) || (state_reg == S_CELL);
        ctl.buf_rd  = (state_reg == S_MOVE);
        ctl.to_buf  = (state_reg == S_COPY);
        ctl.to_grid = (state_reg == S_MOVE);
        access_vec  = {ctl.grid_wr, ctl.grid_rd, ctl.buf_rd};
    end

    assign grid_addr  = gaddr_reg;
    assign grid_wdata = value_reg;
    assign buf_addr   = baddr_reg;
    assign req_ready  = (state_reg == S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_data   = rsp_reg;

    // Checks
    `GRR_ASSERT_NEXT(a_accept_leaves_idle, req_valid && req_ready, state_reg != S_IDLE)
    `GRR_ASSERT(a_one_access, $onehot0(access_vec))
    `GRR_ASSERT_IMPLIES(a_col_in_window,
        (state_reg == S_FILL) || (state_reg == S_COPY) || (state_reg == S_MOVE),
        (j_reg < lim_reg) && (i_reg < lim_reg))
    `GRR_ASSERT_NEXT(a_done_loads, (state_reg == S_DONE) && !rsp_valid_reg,
        rsp_valid_reg && (state_reg == S_IDLE))

endmodule

/* src/grid_region_rotator_core.sv */
// Top level of the grid region rotator: configuration port and block assembly.
// Per transfer: fill writes side*side cells, rotate copies the (2*radius+1)^2 window
// to the buffer and writes it back rotated, read fetches one cell, a flagged or unused
// operation goes straight to the result. One item at a time; a rotate sweeps the
// window with one memory access per cycle.
// Async active-low reset: sequencer idle, no result pending, side 64, grid undefined.
module grid_region_rotator_core #(
    parameter int MAX_SIDE = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  grr_pkg::req_t          req_data,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output grr_pkg::rsp_t          rsp_data
);

    localparam int SW       = grr_pkg::SIDE_W;
    localparam int ADDR_W   = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int CMP_W    = ($clog2(MAX_SIDE + 1) > 8) ? $clog2(MAX_SIDE + 1) : 8;
    localparam int WIN_MAX  = (MAX_SIDE > 63) ? 63 :
                              ((MAX_SIDE % 2 == 1) ? MAX_SIDE : MAX_SIDE - 1);
    localparam int BUF_AW   = (WIN_MAX * WIN_MAX > 1) ? $clog2(WIN_MAX * WIN_MAX) : 1;

    logic [SW-1:0]               side_reg, side_next;
    logic [SW-1:0]               side_eff;
    logic                        cfg_wr;

    grr_pkg::mem_ctl_t           ctl;
    logic [ADDR_W-1:0]           grid_addr;
    logic [grr_pkg::VALUE_W-1:0] grid_wdata;
    logic [grr_pkg::VALUE_W-1:0] grid_rdata;
    logic [BUF_AW-1:0]           buf_addr;

    // Register write decode: every address with paddr[2] clear selects the side register
    always_comb
    begin
        cfg_wr    = psel && penable && pwrite && (paddr[2] == 1'b0);
        side_next = cfg_wr ? pwdata[SW-1:0] : side_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= grr_pkg::SIDE_RESET;
        end
        else
        begin
            side_reg <= side_next;
        end
    end

    // Read back and clamp to the grid size
    always_comb
    begin
        prdata   = (paddr[2] == 1'b0) ? {{(32-SW){1'b0}}, side_reg} : 32'd0;
        side_eff = ({{(CMP_W-SW){1'b0}}, side_reg} > CMP_W'(MAX_SIDE)) ? SW'(MAX_SIDE)
                                                                         : side_reg;
    end

    assign pready = 1'b1;

    grr_seq #(
        .MAX_SIDE (MAX_SIDE)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .side       (side_eff),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_data   (rsp_data),
        .ctl        (ctl),
        .grid_addr  (grid_addr),
        .grid_wdata (grid_wdata),
        .buf_addr   (buf_addr),
        .grid_rdata (grid_rdata)
    );

    grr_store #(
        .MAX_SIDE (MAX_SIDE)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .grid_addr  (grid_addr),
        .grid_wdata (grid_wdata),
        .buf_addr   (buf_addr),
        .grid_rdata (grid_rdata)
    );

endmodule

/* bench/testbench.sv */
// Self-checking testbench for grid_region_rotator_core: random ops checked against a grid model.
`timescale 1ns / 1ps

module testbench;

    localparam int GRID_MAX = 64;
    localparam int WIN_MAX = GRID_MAX - 1;
    localparam int VALUE_W = grr_pkg::VALUE_W;
    localparam int SIDE_W = grr_pkg::SIDE_W;
    localparam int LIMIT_CYCLES = 5_000_000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam logic [2:0] SIDE_ADDR = 3'd0;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic req_valid = 1'b0;
    logic req_ready;
    grr_pkg::req_t req_data = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    grr_pkg::rsp_t rsp_data;

    // Grid model and its copy of the side register
    logic [VALUE_W-1:0] grid_model [0:GRID_MAX*GRID_MAX-1];
    logic [VALUE_W-1:0] window_buf [0:WIN_MAX*WIN_MAX-1];
    logic [SIDE_W-1:0] side_cfg = grr_pkg::SIDE_RESET;

    grr_pkg::req_t pending_reqs[$];
    grr_pkg::rsp_t expected_rsps[$];

    logic req_taken = 1'b0;
    logic rsp_taken = 1'b0;
    int gap_left = 0;
    int ready_wait = 0;
    int req_sent = 0;
    int rsp_count = 0;
    bit long_hold_done = 1'b0;
    int fail_count = 0;
    int cycle_count = 0;

    grid_region_rotator_core #(
        .MAX_SIDE(GRID_MAX)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req_data(req_data),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data(rsp_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // Apply one op to the grid model and return the result it should produce
    function automatic grr_pkg::rsp_t predict_op(input grr_pkg::req_t op);
        int eff;
        int r0;
        int c0;
        int rad;
        int w;
        int top;
        int left;
        int ni;
        int nj;
        grr_pkg::rsp_t res;
        res = '0;
        eff = (int'(side_cfg) > GRID_MAX) ? GRID_MAX : int'(side_cfg);
        r0 = int'(op.row);
        c0 = int'(op.col);
        rad = int'(op.radius);
        case (op.func)
            grr_pkg::FUNC_FILL:
            begin
                for (int r = 0; r < eff; r++)
                    for (int c = 0; c < eff; c++)
                        grid_model[r*GRID_MAX+c] = VALUE_W'(r*eff + c + 1);
            end
            grr_pkg::FUNC_ROTATE:
            begin
                if (r0 < rad || c0 < rad || r0 + rad >= eff || c0 + rad >= eff)
                begin
                    res.status = 1'b1;
                end
                else
                begin
                    w = 2*rad + 1;
                    top = r0 - rad;
                    left = c0 - rad;
                    for (int i = 0; i < w; i++)
                        for (int j = 0; j < w; j++)
                            window_buf[i*WIN_MAX+j] = grid_model[(top+i)*GRID_MAX+left+j];
                    // cw: (i,j) -> (j, w-1-i); ccw: (i,j) -> (w-1-j, i)
                    for (int i = 0; i < w; i++)
                        for (int j = 0; j < w; j++)
                        begin
                            ni = op.counter_clockwise ? (w - 1 - j) : j;
                            nj = op.counter_clockwise ? i : (w - 1 - i);
                            grid_model[(top+ni)*GRID_MAX+left+nj] = window_buf[i*WIN_MAX+j];
                        end
                end
            end
            grr_pkg::FUNC_READ:
            begin
                if (r0 < eff && c0 < eff)
                    res.cell_value = grid_model[r0*GRID_MAX+c0];
                else
                    res.status = 1'b1;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic grr_pkg::req_t make_op(input logic [1:0] f, input int r, input int c,
                                              input int rad, input bit ccw);
        grr_pkg::req_t op;
        op.func = f;
        op.row = 6'(r);
        op.col = 6'(c);
        op.radius = 5'(rad);
        op.counter_clockwise = ccw;
        return op;
    endfunction

    // Mostly in-grid rotates and reads with small windows, plus some raw noise
    function automatic grr_pkg::req_t random_op(input int side);
        int eff;
        int pick;
        int maxr;
        int rad;
        grr_pkg::req_t op;
        eff = (side > GRID_MAX) ? GRID_MAX : side;
        pick = $urandom_range(0, 99);
        op = make_op(grr_pkg::FUNC_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 31), 1'($urandom_range(0, 1)));
        if (pick < 8)
        begin
            op.func = grr_pkg::FUNC_FILL;
        end
        else if (pick < 12)
        begin
            op.func = FUNC_UNUSED;
        end
        else if (pick < 55)
        begin
            op.func = grr_pkg::FUNC_ROTATE;
            if (eff > 0 && $urandom_range(0, 9) < 8)
            begin
                maxr = (eff - 1) / 2;
                if ($urandom_range(0, 15) == 0)
                    rad = $urandom_range(0, maxr);
                else
                    rad = $urandom_range(0, (maxr < 3) ? maxr : 3);
                op.radius = 5'(rad);
                op.row = 6'($urandom_range(rad, eff - 1 - rad));
                op.col = 6'($urandom_range(rad, eff - 1 - rad));
            end
        end
        else if (eff > 0 && $urandom_range(0, 9) < 8)
        begin
            op.row = 6'($urandom_range(0, eff - 1));
            op.col = 6'($urandom_range(0, eff - 1));
        end
        return op;
    endfunction

    // Idle draw with calm stretches of no idling
    function automatic int draw_idle(input int n);
        if ((n / 16) % 3 == 2)
            return 0;
        return $urandom_range(0, 11);
    endfunction

    // Results and transfers, sampled at the rising edge
    always @(posedge clk)
    begin : check_results
        grr_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result value=%0d status=%0d",
                                          rsp_data.cell_value, rsp_data.status));
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp_data.cell_value !== want.cell_value)
                    report_mismatch($sformatf("cell_value got %0d want %0d",
                                              rsp_data.cell_value, want.cell_value));
                if (rsp_data.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              rsp_data.status, want.status));
            end
        end
        if (rst_n && req_valid && req_ready)
            expected_rsps.push_back(predict_op(req_data));
        req_taken <= rst_n && req_valid && req_ready;
        rsp_taken <= rst_n && rsp_valid && rsp_ready;
    end

    // Request driver: holds each item until its transfer, then idles a random gap
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || req_taken)
        begin
            if (req_taken)
            begin
                req_sent++;
                gap_left = draw_idle(req_sent);
            end
            if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                req_data <= pending_reqs.pop_front();
                req_valid <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, one long hold while requests are still queued
    always @(negedge clk)
    begin
        if (rsp_taken)
        begin
            rsp_count++;
            ready_wait = draw_idle(rsp_count);
            if (!long_hold_done && rsp_count >= 40 && pending_reqs.size() >= 3)
            begin
                ready_wait = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
        end
        if (ready_wait > 0)
        begin
            ready_wait--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    // Side register write followed by a read-back
    task automatic write_side(input logic [SIDE_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= SIDE_ADDR;
        pwdata <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        side_cfg = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        psel <= 1'b1;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== 32'(value))
            report_mismatch($sformatf("side read-back got %0d want %0d", prdata, value));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int sides [6];
        int count;
        sides = '{64, 7, 1, 100, 33, 0};
        sides[5] = $urandom_range(2, 64);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: full grid at the reset side, corners, largest windows, flagged windows, unused op
        pending_reqs.push_back(make_op(grr_pkg::FUNC_FILL, 0, 0, 0, 0));
        pending_reqs.push_back(make_op(grr_pkg::FUNC_READ, 0, 0, 0, 0));
        pending_reqs.push_back(make_op(grr_pkg::FUNC_READ, 63, 63, 31, 1));
        pending_reqs.push_back(make_op(grr_pkg::FUNC_READ, 0, 63, 0, 0));
        pending_reqs.push_back(make_op(grr_pkg::FUNC_ROTATE, 31, 31, 31, 0));
        pending_reqs.push_back(make_op(grr_pkg::FUNC_READ, 0, 0, 0, 0));
        pending_reqs.push_back(make_op(grr_pkg::FUNC_ROTATE, 32, 32, 31, 1));
        pending_reqs.push_back(make_op(grr_pkg::FUNC_READ, 63, 63, 0, 0));
        pending_reqs.push_back(make_op(grr_pkg::FUNC_ROTATE, 10, 10, 0, 0));
        pending_reqs.push_back(make_op(grr_pkg::FUNC_ROTATE, 0, 5, 1, 0));
        pending_reqs.push_back(make_op(grr_pkg::FUNC_ROTATE, 5, 0, 1, 1));
        pending_reqs.push_back(make_op(grr_pkg::FUNC_ROTATE, 62, 30, 2, 1));
        pending_reqs.push_back(make_op(grr_pkg::FUNC_ROTATE, 30, 63, 1, 0));
        pending_reqs.push_back(make_op(FUNC_UNUSED, 63, 63, 31, 1));
        pending_reqs.push_back(make_op(grr_pkg::FUNC_ROTATE, 3, 4, 2, 1));
        pending_reqs.push_back(make_op(grr_pkg::FUNC_READ, 1, 2, 0, 0));
        wait_idle();

        // Smallest grid in use
        write_side(7'd1);
        pending_reqs.push_back(make_op(grr_pkg::FUNC_FILL, 0, 0, 0, 0));
        pending_reqs.push_back(make_op(grr_pkg::FUNC_READ, 0, 0, 0, 0));
        pending_reqs.push_back(make_op(grr_pkg::FUNC_READ, 1, 0, 0, 0));
        pending_reqs.push_back(make_op(grr_pkg::FUNC_READ, 0, 1, 0, 0));
        pending_reqs.push_back(make_op(grr_pkg::FUNC_ROTATE, 0, 0, 0, 1));
        pending_reqs.push_back(make_op(grr_pkg::FUNC_ROTATE, 1, 1, 1, 0));
        wait_idle();

        // Side zero: nothing in use, everything but fill flagged
        write_side(7'd0);
        pending_reqs.push_back(make_op(grr_pkg::FUNC_FILL, 0, 0, 0, 0));
        pending_reqs.push_back(make_op(grr_pkg::FUNC_READ, 0, 0, 0, 0));
        pending_reqs.push_back(make_op(grr_pkg::FUNC_ROTATE, 0, 0, 0, 0));
        wait_idle();

        // Side above the maximum acts as the maximum
        write_side(7'd127);
        pending_reqs.push_back(make_op(grr_pkg::FUNC_FILL, 0, 0, 0, 0));
        pending_reqs.push_back(make_op(grr_pkg::FUNC_READ, 63, 63, 0, 0));
        pending_reqs.push_back(make_op(grr_pkg::FUNC_ROTATE, 62, 62, 1, 0));
        wait_idle();

        // Random phases; each starts with a fill so no unwritten cell is touched
        foreach (sides[p])
        begin
            write_side(SIDE_W'(sides[p]));
            pending_reqs.push_back(make_op(grr_pkg::FUNC_FILL, $urandom_range(0, 63),
                                           $urandom_range(0, 63), $urandom_range(0, 31),
                                           1'($urandom_range(0, 1))));
            count = $urandom_range(10, 13);
            repeat (count) pending_reqs.push_back(random_op(sides[p]));
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
